// File: hdl/firmware_image_receiver_crc_check_unit_assert.svh
// Assertion helpers shared by the receiver modules.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef FIRMWARE_IMAGE_RECEIVER_CRC_CHECK_UNIT_ASSERT_SVH
`define FIRMWARE_IMAGE_RECEIVER_CRC_CHECK_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FWRX_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FWRX_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FWRX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/fwrx_pkg.sv
package fwrx_pkg;

	// Image store size in bytes and the widths that follow from it.
	localparam int BUF_BYTES = 262144;
	localparam int CNT_W = $clog2(BUF_BYTES + 1);
	localparam int OFS_W = 18;

	localparam int CAP_W = 25;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(262144);

	localparam int CHUNK_BYTES = 8;
	localparam int CHUNK_W = CHUNK_BYTES * 8;
	localparam int NB_W = $clog2(CHUNK_BYTES + 1);
	localparam int BIDX_W = $clog2(CHUNK_BYTES);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int RES_MAX = 4;
	localparam int RES_IDX_W = $clog2(RES_MAX);
	localparam int RES_N_W = $clog2(RES_MAX + 1);

	localparam int IN_TDATA_W = 136;
	localparam int OUT_TDATA_W = 88;

	// Flash step outcome codes.
	localparam logic [2:0] FO_OK = 3'd0;
	localparam logic [2:0] FO_SIZE = 3'd1;
	localparam logic [2:0] FO_UNLOCK = 3'd2;
	localparam logic [2:0] FO_ERASE = 3'd3;
	localparam logic [2:0] FO_PROGRAM = 3'd4;
	localparam logic [2:0] FO_VERIFY = 3'd5;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_META  = 2'd1,
		OP_CHUNK = 2'd2,
		OP_FLASH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_WRITE      = 3'd0,
		K_ACK        = 3'd1,
		K_STAT_FLASH = 3'd2,
		K_STAT_FAULT = 3'd3,
		K_REPORT     = 3'd4,
		K_RESET      = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		F_NONE    = 3'd0,
		F_SIZE    = 3'd1,
		F_CRC     = 3'd2,
		F_UNLOCK  = 3'd3,
		F_ERASE   = 3'd4,
		F_PROGRAM = 3'd5,
		F_VERIFY  = 3'd6
	} fault_t;

	// What a flash step result asks of the session.
	typedef enum logic [1:0] {
		FA_IGNORE = 2'd0,
		FA_DONE   = 2'd1,
		FA_ABORT  = 2'd2,
		FA_STICK  = 2'd3
	} flash_act_t;

	typedef struct packed {
		op_t                op;
		logic [31:0]        exp_crc;
		logic               size_bad;
		logic [CNT_W-1:0]   size;
		logic [CHUNK_W-1:0] chunk;
		flash_act_t         fact;
		fault_t             ffault;
	} entry_t;

	typedef struct packed {
		kind_t              kind;
		fault_t             fault;
		logic [OFS_W-1:0]   ofs;
		logic [CHUNK_W-1:0] data;
		logic               last;
	} result_t;

	// One byte folded into a reflected CRC-32.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int j = 0; j < 8; j++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: hdl/fwrx_front.sv
module fwrx_front (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fwrx_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [1:0]                        s_tuser,
	input  logic                              full,
	output logic                              push,
	output fwrx_pkg::entry_t                  entry
);

	logic [31:0] image_size;
	logic [2:0]  outcome;

	assign s_tready = !full;
	assign push = s_tvalid && !full;

	assign image_size = s_tdata[63:32];
	assign outcome = s_tdata[130:128];

	always_comb begin
		entry.op = fwrx_pkg::op_t'(s_tuser);
		entry.exp_crc = s_tdata[31:0];
		entry.size_bad = (image_size == 32'd0) || (image_size > 32'(fwrx_pkg::BUF_BYTES));
		entry.size = image_size[fwrx_pkg::CNT_W-1:0];
		entry.chunk = s_tdata[127:64];
		case (outcome)
			fwrx_pkg::FO_OK: begin
				entry.fact = fwrx_pkg::FA_DONE;
				entry.ffault = fwrx_pkg::F_NONE;
			end
			fwrx_pkg::FO_SIZE: begin
				entry.fact = fwrx_pkg::FA_ABORT;
				entry.ffault = fwrx_pkg::F_SIZE;
			end
			fwrx_pkg::FO_UNLOCK: begin
				entry.fact = fwrx_pkg::FA_ABORT;
				entry.ffault = fwrx_pkg::F_UNLOCK;
			end
			fwrx_pkg::FO_ERASE: begin
				entry.fact = fwrx_pkg::FA_STICK;
				entry.ffault = fwrx_pkg::F_ERASE;
			end
			fwrx_pkg::FO_PROGRAM: begin
				entry.fact = fwrx_pkg::FA_STICK;
				entry.ffault = fwrx_pkg::F_PROGRAM;
			end
			fwrx_pkg::FO_VERIFY: begin
				entry.fact = fwrx_pkg::FA_STICK;
				entry.ffault = fwrx_pkg::F_VERIFY;
			end
			default: begin
				entry.fact = fwrx_pkg::FA_IGNORE;
				entry.ffault = fwrx_pkg::F_NONE;
			end
		endcase
	end

endmodule

// File: hdl/fwrx_queue.sv
`include "firmware_image_receiver_crc_check_unit_assert.svh"

module fwrx_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fwrx_pkg::entry_t push_entry,
	input  logic             pop,
	output fwrx_pkg::entry_t head,
	output logic             full,
	output logic             empty
);

	fwrx_pkg::entry_t              slot_q [fwrx_pkg::QUEUE_DEPTH];
	logic [fwrx_pkg::QPTR_W-1:0]   wr_q;
	logic [fwrx_pkg::QPTR_W-1:0]   rd_q;
	logic [fwrx_pkg::QCNT_W-1:0]   cnt_q;

	assign full = (cnt_q == fwrx_pkg::QCNT_W'(fwrx_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == fwrx_pkg::QPTR_W'(fwrx_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == fwrx_pkg::QPTR_W'(fwrx_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`FWRX_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= fwrx_pkg::QCNT_W'(fwrx_pkg::QUEUE_DEPTH), "queue count overflow")
	`FWRX_ASSERT_IMPLY(a_no_push_full, full, !push, "request written into a full queue")
	`FWRX_ASSERT_IMPLY(a_no_pop_empty, empty, !pop, "request taken from an empty queue")

endmodule

// File: hdl/fwrx_back.sv
`include "firmware_image_receiver_crc_check_unit_assert.svh"

module fwrx_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fwrx_pkg::entry_t              head,
	input  logic                          empty,
	output logic                          pop,
	input  logic [fwrx_pkg::CAP_W-1:0]    capacity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output fwrx_pkg::result_t             out_res
);

	typedef enum logic [1:0] {
		SQ_IDLE = 2'd0,
		SQ_CRC  = 2'd1,
		SQ_EMIT = 2'd2
	} seq_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RECV  = 2'd1,
		PH_FLASH = 2'd2,
		PH_FAULT = 2'd3
	} phase_t;

	seq_t                              seq_q, seq_d;
	phase_t                            phase_q, phase_d;
	logic                              meta_q, meta_d;
	logic [fwrx_pkg::CNT_W-1:0]        bytes_q, bytes_d;
	logic [fwrx_pkg::CNT_W-1:0]        size_q, size_d;
	logic [31:0]                       tcrc_q, tcrc_d;
	logic [31:0]                       crc_q, crc_d;
	logic [fwrx_pkg::BIDX_W-1:0]       byte_idx_q;
	logic [fwrx_pkg::NB_W-1:0]         nbytes_q;
	logic [fwrx_pkg::CHUNK_W-1:0]      chunk_q;
	logic [fwrx_pkg::OFS_W-1:0]        ofs_q;
	fwrx_pkg::kind_t                   res_kind_q [fwrx_pkg::RES_MAX];
	fwrx_pkg::fault_t                  res_fault_q [fwrx_pkg::RES_MAX];
	logic [fwrx_pkg::RES_N_W-1:0]      res_n_q;
	logic [fwrx_pkg::RES_IDX_W-1:0]    res_i_q;
	logic                              out_valid_q;
	fwrx_pkg::result_t                 out_res_q;

	fwrx_pkg::kind_t                   res_kind_d [fwrx_pkg::RES_MAX];
	fwrx_pkg::fault_t                  res_fault_d [fwrx_pkg::RES_MAX];
	logic [fwrx_pkg::RES_N_W-1:0]      res_n_d;
	logic                              res_ld;
	logic                              clr;
	logic                              chunk_ld;
	logic [fwrx_pkg::CNT_W-1:0]        rem;
	logic [fwrx_pkg::NB_W-1:0]         cnt;
	logic [fwrx_pkg::CHUNK_W-1:0]      masked;
	logic [31:0]                       crc_next;
	logic                              fin;
	logic [fwrx_pkg::CNT_W-1:0]        bytes_new;
	logic                              over_cap;
	logic                              res_last;
	logic                              out_free;

	assign pop = (seq_q == SQ_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign out_res = out_res_q;

	assign rem = size_q - bytes_q;
	assign cnt = (rem < fwrx_pkg::CNT_W'(fwrx_pkg::CHUNK_BYTES)) ?
		rem[fwrx_pkg::NB_W-1:0] : fwrx_pkg::NB_W'(fwrx_pkg::CHUNK_BYTES);

	// Bytes beyond the announced size are dropped from the write and the CRC.
	always_comb begin
		for (int i = 0; i < fwrx_pkg::CHUNK_BYTES; i++) begin
			masked[i*8 +: 8] = (fwrx_pkg::NB_W'(i) < cnt) ? head.chunk[i*8 +: 8] : 8'd0;
		end
	end

	assign crc_next = fwrx_pkg::crc_byte(crc_q, chunk_q[{byte_idx_q, 3'b000} +: 8]);
	assign fin = (seq_q == SQ_CRC) && ({1'b0, byte_idx_q} == nbytes_q - 1'b1);
	assign bytes_new = bytes_q + fwrx_pkg::CNT_W'(nbytes_q);
	assign over_cap = fwrx_pkg::CAP_W'(size_q) > capacity;
	assign res_last = ({1'b0, res_i_q} == res_n_q - 1'b1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		seq_d = seq_q;
		phase_d = phase_q;
		meta_d = meta_q;
		bytes_d = bytes_q;
		size_d = size_q;
		tcrc_d = tcrc_q;
		crc_d = crc_q;
		res_ld = 1'b0;
		res_n_d = '0;
		clr = 1'b0;
		chunk_ld = 1'b0;
		for (int k = 0; k < fwrx_pkg::RES_MAX; k++) begin
			res_kind_d[k] = fwrx_pkg::K_ACK;
			res_fault_d[k] = fwrx_pkg::F_NONE;
		end
		case (seq_q)
			SQ_IDLE: begin
				if (pop) begin
					case (head.op)
						fwrx_pkg::OP_INIT: begin
							if (phase_q == PH_IDLE) begin
								phase_d = PH_RECV;
								meta_d = 1'b0;
								bytes_d = '0;
								size_d = '0;
								tcrc_d = '0;
								crc_d = fwrx_pkg::CRC_ONES;
								res_ld = 1'b1;
								res_n_d = fwrx_pkg::RES_N_W'(1);
							end
						end
						fwrx_pkg::OP_META: begin
							if (phase_q == PH_RECV && !meta_q) begin
								if (head.size_bad) begin
									res_kind_d[0] = fwrx_pkg::K_REPORT;
									res_fault_d[0] = fwrx_pkg::F_SIZE;
									res_kind_d[1] = fwrx_pkg::K_RESET;
									res_n_d = fwrx_pkg::RES_N_W'(2);
									res_ld = 1'b1;
									clr = 1'b1;
								end else begin
									tcrc_d = head.exp_crc;
									size_d = head.size;
									meta_d = 1'b1;
								end
							end
						end
						fwrx_pkg::OP_CHUNK: begin
							if (phase_q == PH_RECV && meta_q && bytes_q < size_q) begin
								chunk_ld = 1'b1;
								seq_d = SQ_CRC;
							end
						end
						fwrx_pkg::OP_FLASH: begin
							if (phase_q == PH_FLASH) begin
								case (head.fact)
									fwrx_pkg::FA_DONE: begin
										res_kind_d[0] = fwrx_pkg::K_RESET;
										res_n_d = fwrx_pkg::RES_N_W'(1);
										res_ld = 1'b1;
										clr = 1'b1;
									end
									fwrx_pkg::FA_ABORT: begin
										res_kind_d[0] = fwrx_pkg::K_REPORT;
										res_fault_d[0] = head.ffault;
										res_kind_d[1] = fwrx_pkg::K_RESET;
										res_n_d = fwrx_pkg::RES_N_W'(2);
										res_ld = 1'b1;
										clr = 1'b1;
									end
									fwrx_pkg::FA_STICK: begin
										// The fault phase ignores everything, so this report is the only one.
										res_kind_d[0] = fwrx_pkg::K_REPORT;
										res_fault_d[0] = head.ffault;
										res_n_d = fwrx_pkg::RES_N_W'(1);
										res_ld = 1'b1;
										phase_d = PH_FAULT;
									end
									default: begin
									end
								endcase
							end
						end
						default: begin
						end
					endcase
					if (res_ld) begin
						seq_d = SQ_EMIT;
					end
				end
			end
			SQ_CRC: begin
				crc_d = crc_next;
				if (fin) begin
					bytes_d = bytes_new;
					res_kind_d[0] = fwrx_pkg::K_WRITE;
					res_n_d = fwrx_pkg::RES_N_W'(1);
					res_ld = 1'b1;
					seq_d = SQ_EMIT;
					// Last byte of the image: validate straight away.
					if (bytes_new == size_q) begin
						if ((crc_next ^ fwrx_pkg::CRC_ONES) != tcrc_q) begin
							res_kind_d[1] = fwrx_pkg::K_STAT_FAULT;
							res_fault_d[1] = fwrx_pkg::F_CRC;
							res_kind_d[2] = fwrx_pkg::K_REPORT;
							res_fault_d[2] = fwrx_pkg::F_CRC;
							res_kind_d[3] = fwrx_pkg::K_RESET;
							res_n_d = fwrx_pkg::RES_N_W'(4);
							clr = 1'b1;
						end else begin
							res_kind_d[1] = fwrx_pkg::K_STAT_FLASH;
							res_n_d = fwrx_pkg::RES_N_W'(2);
							phase_d = PH_FLASH;
							if (over_cap) begin
								res_kind_d[2] = fwrx_pkg::K_REPORT;
								res_fault_d[2] = fwrx_pkg::F_SIZE;
								res_kind_d[3] = fwrx_pkg::K_RESET;
								res_n_d = fwrx_pkg::RES_N_W'(4);
								clr = 1'b1;
							end
						end
					end
				end
			end
			SQ_EMIT: begin
				if (out_free && res_last) begin
					seq_d = SQ_IDLE;
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
		if (clr) begin
			phase_d = PH_IDLE;
			meta_d = 1'b0;
			bytes_d = '0;
			size_d = '0;
			tcrc_d = '0;
			crc_d = fwrx_pkg::CRC_ONES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
			phase_q <= PH_IDLE;
			meta_q <= 1'b0;
			bytes_q <= '0;
			size_q <= '0;
			tcrc_q <= '0;
			crc_q <= fwrx_pkg::CRC_ONES;
			byte_idx_q <= '0;
			nbytes_q <= '0;
			res_n_q <= '0;
			res_i_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			phase_q <= phase_d;
			meta_q <= meta_d;
			bytes_q <= bytes_d;
			size_q <= size_d;
			tcrc_q <= tcrc_d;
			crc_q <= crc_d;
			if (chunk_ld) begin
				nbytes_q <= cnt;
				byte_idx_q <= '0;
			end else if (seq_q == SQ_CRC) begin
				byte_idx_q <= byte_idx_q + 1'b1;
			end
			if (res_ld) begin
				res_n_q <= res_n_d;
				res_i_q <= '0;
			end else if (seq_q == SQ_EMIT && out_free) begin
				res_i_q <= res_i_q + 1'b1;
			end
			if (seq_q == SQ_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_ld) begin
			chunk_q <= masked;
			ofs_q <= bytes_q[fwrx_pkg::OFS_W-1:0];
		end
		if (res_ld) begin
			for (int k = 0; k < fwrx_pkg::RES_MAX; k++) begin
				res_kind_q[k] <= res_kind_d[k];
				res_fault_q[k] <= res_fault_d[k];
			end
		end
		if (seq_q == SQ_EMIT && out_free) begin
			out_res_q.kind <= res_kind_q[res_i_q];
			out_res_q.fault <= res_fault_q[res_i_q];
			out_res_q.last <= res_last;
			if (res_kind_q[res_i_q] == fwrx_pkg::K_WRITE) begin
				out_res_q.ofs <= ofs_q;
				out_res_q.data <= chunk_q;
			end else begin
				out_res_q.ofs <= '0;
				out_res_q.data <= '0;
			end
		end
	end

	`FWRX_ASSERT_IMPLY(a_emit_list, seq_q == SQ_EMIT, res_n_q != '0 && {1'b0, res_i_q} < res_n_q, "result index outside the pending list")
	`FWRX_ASSERT_IMPLY(a_crc_range, seq_q == SQ_CRC, {1'b0, byte_idx_q} < nbytes_q && nbytes_q <= fwrx_pkg::NB_W'(fwrx_pkg::CHUNK_BYTES), "CRC byte walk out of range")
	`FWRX_ASSERT_IMPLY(a_bytes_bound, meta_q, bytes_q <= size_q, "received more bytes than announced")
	`FWRX_ASSERT_NEXT(a_fault_sticky, phase_q == PH_FAULT, phase_q == PH_FAULT, "fault phase left without reset")

endmodule

// File: hdl/firmware_image_receiver_crc_check_unit.sv
// Firmware image receiver with CRC-32 check.
// Requests enter on the s_* channel (tuser holds the operation) and are held in a
// four-entry queue, so the sender is only stalled when the queue is full. The back
// end takes one request at a time and drives the m_* channel through an output
// register; m_tlast marks the final result of a request.
// The back end takes a request from the queue, then for a chunk walks its valid
// bytes one at a time through the byte-wide CRC unit, then sends its results in order.
// A chunk that does not end the image carries one result; other requests carry up
// to 2 results, and the last chunk of an image carries up to 4 results. When the
// back end is waiting, an accepted request passes through the queue, the sequencer
// and, for a chunk, the CRC byte walk before the output register raises m_tvalid.
// cfg_* writes the flash capacity register and is always ready. The user must write
// it only while no request is in progress; the block itself does not enforce this.
// arst_n clears the queue, the output register and the session, and restores the
// capacity to its default. If m_tready stays low the output register holds its
// result, the back end waits, and the queue fills until s_tready drops.
module firmware_image_receiver_crc_check_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// expected_crc[31:0], image_size[63:32], chunk_data[127:64], flash_outcome[130:128]
	input  logic [fwrx_pkg::IN_TDATA_W-1:0]       s_tdata,
	// operation[1:0]
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// fault_code[2:0], write_offset[20:3], write_data[84:21]
	output logic [fwrx_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// kind[2:0]
	output logic [2:0]                            m_tuser,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fwrx_pkg::CAP_W-1:0]            cfg_data
);

	fwrx_pkg::entry_t             push_entry;
	fwrx_pkg::entry_t             head;
	fwrx_pkg::result_t            res;
	logic                         push;
	logic                         pop;
	logic                         full;
	logic                         empty;
	logic [fwrx_pkg::CAP_W-1:0]   cap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= fwrx_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	fwrx_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push),
		.entry    (push_entry)
	);

	fwrx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	fwrx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.capacity  (cap_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {3'b000, res.data, res.ofs, res.fault};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

// File: tb/tb_top.sv
module tb_top;

	localparam int STALL_LIMIT = 4000;

	typedef enum logic [1:0] {
		SESS_IDLE,
		SESS_RECEIVING,
		SESS_FLASHING,
		SESS_FAULT
	} sess_phase_t;

	typedef struct {
		fwrx_pkg::kind_t  kind;
		fwrx_pkg::fault_t fault;
		logic [17:0]      ofs;
		logic [63:0]      data;
		logic             last;
	} session_event_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [fwrx_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]                       s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [fwrx_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]                       m_tuser;
	logic                             m_tlast;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [fwrx_pkg::CAP_W-1:0]       cfg_data = '0;

	// Session as the block should see it.
	sess_phase_t                sess_phase = SESS_IDLE;
	bit                         meta_seen;
	int                         byte_cnt;
	int                         want_size;
	logic [31:0]                want_crc;
	logic [31:0]                crc_acc = fwrx_pkg::CRC_ONES;
	fwrx_pkg::fault_t           fault_latched = fwrx_pkg::F_NONE;
	bit                         fault_told;
	logic [fwrx_pkg::CAP_W-1:0] capacity = fwrx_pkg::CAP_RESET;

	session_event_t expected_events[$];
	int fail_count;
	int effective_requests;
	int stall_cycles;
	int sender_idle_pct;
	int receiver_stall_pct;
	int noise_pct;

	firmware_image_receiver_crc_check_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	function automatic logic [31:0] crc32_fold_byte(logic [31:0] acc, logic [7:0] b);
		logic [31:0] r = acc;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ b[k]) begin
				r = (r >> 1) ^ fwrx_pkg::CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] image_crc(logic [63:0] img[$], int nbytes);
		logic [31:0] r = fwrx_pkg::CRC_ONES;
		for (int i = 0; i < nbytes; i++) begin
			r = crc32_fold_byte(r, img[i / 8][8 * (i % 8) +: 8]);
		end
		return ~r;
	endfunction

	function automatic session_event_t mk_event(fwrx_pkg::kind_t kind, fwrx_pkg::fault_t fault,
			logic [17:0] ofs, logic [63:0] data);
		session_event_t e;
		e.kind = kind;
		e.fault = fault;
		e.ofs = ofs;
		e.data = data;
		e.last = 1'b0;
		return e;
	endfunction

	function automatic void clear_session();
		sess_phase = SESS_IDLE;
		meta_seen = 0;
		byte_cnt = 0;
		want_size = 0;
		want_crc = '0;
		crc_acc = fwrx_pkg::CRC_ONES;
		fault_latched = fwrx_pkg::F_NONE;
		fault_told = 0;
	endfunction

	// Works out the results of one accepted request and queues them; returns whether the
	// request did anything at all.
	function automatic bit advance_session(fwrx_pkg::op_t op, logic [31:0] crc_in,
			logic [31:0] size_in, logic [63:0] chunk_in, logic [2:0] fo);
		session_event_t evs[$];
		bit took_meta = 0;
		int take;
		logic [63:0] wdata;
		case (op)
			fwrx_pkg::OP_INIT: begin
				if (sess_phase == SESS_IDLE) begin
					clear_session();
					sess_phase = SESS_RECEIVING;
					evs.push_back(mk_event(fwrx_pkg::K_ACK, fwrx_pkg::F_NONE, '0, '0));
				end
			end
			fwrx_pkg::OP_META: begin
				if (sess_phase == SESS_RECEIVING && !meta_seen) begin
					if (size_in == 0 || size_in > fwrx_pkg::BUF_BYTES) begin
						evs.push_back(mk_event(fwrx_pkg::K_REPORT, fwrx_pkg::F_SIZE, '0, '0));
						evs.push_back(mk_event(fwrx_pkg::K_RESET, fwrx_pkg::F_NONE, '0, '0));
						clear_session();
					end else begin
						want_crc = crc_in;
						want_size = int'(size_in);
						meta_seen = 1;
						took_meta = 1;
					end
				end
			end
			fwrx_pkg::OP_CHUNK: begin
				if (sess_phase == SESS_RECEIVING && meta_seen && byte_cnt < want_size) begin
					take = (want_size - byte_cnt < 8) ? want_size - byte_cnt : 8;
					wdata = '0;
					for (int i = 0; i < take; i++) begin
						wdata[8 * i +: 8] = chunk_in[8 * i +: 8];
						crc_acc = crc32_fold_byte(crc_acc, chunk_in[8 * i +: 8]);
					end
					evs.push_back(mk_event(fwrx_pkg::K_WRITE, fwrx_pkg::F_NONE,
						byte_cnt[17:0], wdata));
					byte_cnt += take;
					if (byte_cnt == want_size) begin
						if (~crc_acc != want_crc) begin
							evs.push_back(mk_event(fwrx_pkg::K_STAT_FAULT, fwrx_pkg::F_CRC,
								'0, '0));
							evs.push_back(mk_event(fwrx_pkg::K_REPORT, fwrx_pkg::F_CRC,
								'0, '0));
							evs.push_back(mk_event(fwrx_pkg::K_RESET, fwrx_pkg::F_NONE,
								'0, '0));
							clear_session();
						end else begin
							evs.push_back(mk_event(fwrx_pkg::K_STAT_FLASH, fwrx_pkg::F_NONE,
								'0, '0));
							sess_phase = SESS_FLASHING;
							if (want_size > int'(capacity)) begin
								evs.push_back(mk_event(fwrx_pkg::K_REPORT, fwrx_pkg::F_SIZE,
									'0, '0));
								evs.push_back(mk_event(fwrx_pkg::K_RESET, fwrx_pkg::F_NONE,
									'0, '0));
								clear_session();
							end
						end
					end
				end
			end
			default: begin
				if (sess_phase == SESS_FLASHING && fo <= fwrx_pkg::FO_VERIFY) begin
					if (fo == fwrx_pkg::FO_OK) begin
						evs.push_back(mk_event(fwrx_pkg::K_RESET, fwrx_pkg::F_NONE, '0, '0));
						clear_session();
					end else if (fo == fwrx_pkg::FO_SIZE || fo == fwrx_pkg::FO_UNLOCK) begin
						evs.push_back(mk_event(fwrx_pkg::K_REPORT,
							(fo == fwrx_pkg::FO_SIZE) ? fwrx_pkg::F_SIZE : fwrx_pkg::F_UNLOCK,
							'0, '0));
						evs.push_back(mk_event(fwrx_pkg::K_RESET, fwrx_pkg::F_NONE, '0, '0));
						clear_session();
					end else begin
						// Erase, program and verify faults leave the session stuck in fault.
						fault_latched = fwrx_pkg::fault_t'(fo + 3'd1);
						sess_phase = SESS_FAULT;
						if (!fault_told) begin
							evs.push_back(mk_event(fwrx_pkg::K_REPORT, fault_latched, '0, '0));
							fault_told = 1;
						end
					end
				end
			end
		endcase
		if (evs.size() > 0) begin
			evs[evs.size() - 1].last = 1'b1;
		end
		foreach (evs[i]) begin
			expected_events.push_back(evs[i]);
		end
		return (evs.size() > 0) || took_meta;
	endfunction

	// A flash outcome that never ends the session for good.
	function automatic logic [2:0] benign_outcome();
		int pick = $urandom_range(4);
		return (pick < 3) ? 3'(pick) : 3'(pick + 3);
	endfunction

	task automatic push_one(fwrx_pkg::op_t op, logic [31:0] crc, logic [31:0] size,
			logic [63:0] chunk, logic [2:0] fo);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, fo, chunk, size, crc};
		do @(posedge clk); while (!s_tready);
		if (advance_session(op, crc, size, chunk, fo)) begin
			effective_requests++;
		end
	endtask

	task automatic send_request(fwrx_pkg::op_t op, logic [31:0] crc, logic [31:0] size,
			logic [63:0] chunk, logic [2:0] fo);
		if ($urandom_range(99) < noise_pct) begin
			// Stray request; its size is always too large to open an image.
			push_one(fwrx_pkg::op_t'($urandom_range(3)), $urandom, $urandom | 32'h0008_0000,
				{$urandom, $urandom}, benign_outcome());
		end
		push_one(op, crc, size, chunk, fo);
	endtask

	task automatic write_capacity(logic [fwrx_pkg::CAP_W-1:0] value);
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) begin
			@(posedge clk);
		end
		// Requests that give no result may still be queued inside the block.
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity = value;
	endtask

	task automatic send_image(int nbytes, bit crc_good, int nsend);
		logic [63:0] img[$];
		logic [31:0] crc;
		int nchunks = (nbytes + 7) / 8;
		for (int i = 0; i < nchunks; i++) begin
			img.push_back({$urandom, $urandom});
		end
		crc = image_crc(img, nbytes);
		if (!crc_good) begin
			crc ^= ($urandom | 32'd1);
		end
		send_request(fwrx_pkg::OP_INIT, $urandom, $urandom, {$urandom, $urandom},
			benign_outcome());
		send_request(fwrx_pkg::OP_META, crc, nbytes, {$urandom, $urandom}, benign_outcome());
		for (int i = 0; i < nchunks && i < nsend; i++) begin
			send_request(fwrx_pkg::OP_CHUNK, $urandom, $urandom, img[i], benign_outcome());
		end
	endtask

	task automatic return_to_idle();
		while (sess_phase == SESS_RECEIVING || sess_phase == SESS_FLASHING) begin
			if (sess_phase == SESS_FLASHING) begin
				send_request(fwrx_pkg::OP_FLASH, $urandom, $urandom, {$urandom, $urandom},
					fwrx_pkg::FO_OK);
			end else if (!meta_seen) begin
				send_request(fwrx_pkg::OP_META, $urandom, 32'd0, {$urandom, $urandom},
					fwrx_pkg::FO_OK);
			end else begin
				send_request(fwrx_pkg::OP_CHUNK, $urandom, $urandom, {$urandom, $urandom},
					fwrx_pkg::FO_OK);
			end
		end
	endtask

	task automatic test_misplaced_events();
		send_request(fwrx_pkg::OP_META, 32'h1234_5678, 32'd4, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_CHUNK, 32'd0, 32'd0, {$urandom, $urandom}, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_FLASH, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_FLASH, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		// A chunk before the metadata is dropped.
		send_request(fwrx_pkg::OP_CHUNK, 32'd0, 32'd0, {$urandom, $urandom}, fwrx_pkg::FO_OK);
	endtask

	task automatic test_size_faults();
		send_request(fwrx_pkg::OP_META, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_META, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_META, 32'd0, fwrx_pkg::BUF_BYTES + 1, 64'd0, fwrx_pkg::FO_OK);
	endtask

	task automatic test_partial_image();
		logic [63:0] img[$];
		img.push_back({$urandom, $urandom});
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_META, image_crc(img, 5), 32'd5, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_CHUNK, 32'd0, 32'd0, img[0], fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_FLASH, 32'd0, 32'd0, 64'd0, 3'd6);
		send_request(fwrx_pkg::OP_FLASH, 32'd0, 32'd0, 64'd0, 3'd7);
		send_request(fwrx_pkg::OP_FLASH, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
	endtask

	task automatic test_crc_fault();
		logic [63:0] img[$];
		img.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_META, image_crc(img, 8) ^ 32'h8000_0001, 32'd8, 64'd0,
			fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_CHUNK, 32'd0, 32'd0, img[0], fwrx_pkg::FO_OK);
	endtask

	task automatic test_capacity_fault();
		logic [63:0] img[$];
		img.push_back(64'd0);
		write_capacity(fwrx_pkg::CAP_W'(1));
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_META, image_crc(img, 8), 32'd8, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_CHUNK, 32'd0, 32'd0, img[0], fwrx_pkg::FO_OK);
	endtask

	task automatic test_random_sessions(int idle_pct, int stall_pct,
			logic [fwrx_pkg::CAP_W-1:0] cap);
		int goal;
		int nbytes;
		int shape;
		write_capacity(cap);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		noise_pct = 8;
		goal = effective_requests + 36;
		while (effective_requests < goal) begin
			return_to_idle();
			nbytes = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
			shape = $urandom_range(99);
			if (shape >= 90) begin
				send_request(fwrx_pkg::OP_INIT, $urandom, $urandom, {$urandom, $urandom},
					fwrx_pkg::FO_OK);
				send_request(fwrx_pkg::OP_CHUNK, $urandom, $urandom, {$urandom, $urandom},
					fwrx_pkg::FO_OK);
			end
			if (shape >= 80 && shape < 90) begin
				send_image(nbytes, 1, $urandom_range((nbytes - 1) / 8, 0));
			end else begin
				send_image(nbytes, !(shape >= 70 && shape < 80), 1000);
			end
			if (sess_phase == SESS_FLASHING) begin
				send_request(fwrx_pkg::OP_FLASH, $urandom, $urandom, {$urandom, $urandom},
					($urandom_range(2) == 0) ? fwrx_pkg::FO_OK : benign_outcome());
			end
		end
		noise_pct = 0;
	endtask

	// Must run last: an erase, program or verify fault holds until reset.
	task automatic test_sticky_flash_fault();
		return_to_idle();
		send_image($urandom_range(20, 1), 1, 1000);
		send_request(fwrx_pkg::OP_FLASH, $urandom, $urandom, {$urandom, $urandom},
			3'($urandom_range(fwrx_pkg::FO_VERIFY, fwrx_pkg::FO_ERASE)));
		send_request(fwrx_pkg::OP_INIT, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
		send_request(fwrx_pkg::OP_FLASH, 32'd0, 32'd0, 64'd0, fwrx_pkg::FO_OK);
	endtask

	always @(posedge clk) begin : check_results
		session_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result: kind %0d fault %0d offset %0d data %h last %b",
					$time, m_tuser, m_tdata[2:0], m_tdata[20:3], m_tdata[84:21], m_tlast);
			end else begin
				want = expected_events.pop_front();
				if (m_tuser !== want.kind || m_tdata[2:0] !== want.fault ||
						m_tdata[20:3] !== want.ofs || m_tdata[84:21] !== want.data ||
						m_tlast !== want.last) begin
					fail_count++;
					$display("%0t: expected kind %0d fault %0d offset %0d data %h last %b",
						$time, want.kind, want.fault, want.ofs, want.data, want.last);
					$display("%0t: actual   kind %0d fault %0d offset %0d data %h last %b",
						$time, m_tuser, m_tdata[2:0], m_tdata[20:3], m_tdata[84:21], m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("firmware_image_receiver_crc_check_unit: mismatch");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_misplaced_events();
		test_size_faults();
		test_partial_image();
		test_crc_fault();
		test_capacity_fault();
		test_random_sessions(0, 0, fwrx_pkg::CAP_W'(24'hFF_FFFF) + fwrx_pkg::CAP_W'(1));
		test_random_sessions(63, 0, fwrx_pkg::CAP_W'(1));
		test_random_sessions(0, 63, fwrx_pkg::CAP_W'($urandom_range(64, 1)));
		test_random_sessions(21, 21, fwrx_pkg::CAP_RESET);
		test_sticky_flash_fault();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("firmware_image_receiver_crc_check_unit: match");
		end else begin
			$display("firmware_image_receiver_crc_check_unit: mismatch");
		end
		$finish;
	end

endmodule
